@@ hw/rtl/arpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache and responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES = 16;
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;

  localparam int unsigned IP_W  = 32;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [10:0]      MIN_ARP_LEN   = 11'd28;
  localparam logic [15:0]      HW_ETHERNET   = 16'h0001;
  localparam logic [15:0]      PROTO_IPV4    = 16'h0800;
  localparam logic [15:0]      OPC_REQUEST   = 16'h0001;
  localparam logic [15:0]      OPC_REPLY     = 16'h0002;
  localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_RX_ARP   = 2'd1,
    OP_SEND_REQ = 2'd2
  } operation_e;

  typedef enum logic [1:0] {
    FRAME_NONE    = 2'd0,
    FRAME_REPLY   = 2'd1,
    FRAME_REQUEST = 2'd2
  } frame_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_IP  = 1'd0,
    REG_OWN_MAC = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOOKUP,
    CMD_LEARN,
    CMD_ANSWER,
    CMD_REQUEST
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } cmd_t;

endpackage

@@ hw/rtl/arpc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_req_if / arpc_rsp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [10:0] packet_length;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [15:0] arp_opcode;
  logic [31:0] src_ip;
  logic [47:0] src_mac;
  logic [31:0] dst_ip;

  modport source (
    output valid, operation, packet_length, hw_type, proto_type, arp_opcode,
           src_ip, src_mac, dst_ip,
    input  ready
  );
  modport sink (
    input  valid, operation, packet_length, hw_type, proto_type, arp_opcode,
           src_ip, src_mac, dst_ip,
    output ready
  );
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        lookup_hit;
  logic [47:0] found_mac;
  logic        cache_written;
  logic [1:0]  frame_kind;
  logic [47:0] frame_dest_mac;
  logic [47:0] frame_target_mac;
  logic [31:0] frame_target_ip;

  modport source (
    output valid, lookup_hit, found_mac, cache_written, frame_kind,
           frame_dest_mac, frame_target_mac, frame_target_ip,
    input  ready
  );
  modport sink (
    input  valid, lookup_hit, found_mac, cache_written, frame_kind,
           frame_dest_mac, frame_target_mac, frame_target_ip,
    output ready
  );
endinterface

@@ hw/rtl/arp_cache_responder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_responder_top
// ARP cache and responder: IPv4-to-MAC cache lookups, learning from
// received ARP packets, reply and request frame field generation.
//
// Channels: req_i (sink) carries one item per transaction: lookup, received
// ARP packet or send-request. rsp_o (source) returns exactly one result
// transaction per item, in order. cfg_we_i/cfg_idx_i/cfg_wdata_i write
// own_ip (index 0); a write to index 1 (own_mac) is ignored;
// write only while idle. An accepted item is written into the command
// queue, then its CAM access result is captured in the output register.
// Throughput: one item per cycle while rsp_o.ready is high; the 16-entry
// register CAM is searched and written in the same cycle.
// Reset: clears all cache valid bits, own_ip, the queue and the output valid.
// Stall: while rsp_o.ready is low the result holds; the two-entry command
// queue keeps absorbing items, and req_i.ready drops once it is full.
// ----------------------------------------------------------------------------
module arp_cache_responder_top
  import arpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  arpc_req_if.sink              req_i,
  arpc_rsp_if.source            rsp_o
);

  cmd_t push_cmd, pop_cmd;
  logic cmd_push, cmd_full, cmd_valid, cmd_pop;

  arpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd),
    .cmd_full_i  (cmd_full)
  );

  arpc_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (push_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (pop_cmd)
  );

  arpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

@@ hw/rtl/arpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_front
// Accepts input transactions, checks received ARP packets and turns each
// item into a cache command for the back end.
// ----------------------------------------------------------------------------
module arpc_front
  import arpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  arpc_req_if.sink              req_i,
  output logic                  cmd_push_o,
  output cmd_t                  cmd_o,
  input  logic                  cmd_full_i
);

  logic [IP_W-1:0] own_ip_q;
  logic            pkt_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == REG_OWN_IP) begin
      own_ip_q <= cfg_wdata_i[IP_W-1:0];
    end
  end

  assign req_i.ready = !cmd_full_i;
  assign cmd_push_o  = req_i.valid && !cmd_full_i;

  assign pkt_ok = (req_i.packet_length >= MIN_ARP_LEN) &&
                  (req_i.hw_type == HW_ETHERNET) &&
                  (req_i.proto_type == PROTO_IPV4);

  always_comb begin
    cmd_o.kind = CMD_NONE;
    cmd_o.ip   = req_i.dst_ip;
    cmd_o.mac  = req_i.src_mac;
    unique case (req_i.operation)
      OP_LOOKUP: begin
        cmd_o.kind = CMD_LOOKUP;
      end
      OP_RX_ARP: begin
        cmd_o.ip = req_i.src_ip;
        if (pkt_ok) begin
          if (req_i.arp_opcode == OPC_REQUEST && req_i.dst_ip == own_ip_q) begin
            cmd_o.kind = CMD_ANSWER;
          end else if (req_i.arp_opcode == OPC_REPLY) begin
            cmd_o.kind = CMD_LEARN;
          end
        end
      end
      OP_SEND_REQ: begin
        cmd_o.kind = CMD_REQUEST;
      end
      default: begin
        cmd_o.kind = CMD_NONE;
      end
    endcase
  end

endmodule

@@ hw/rtl/arpc_cmd_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_cmd_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module arpc_cmd_fifo
  import arpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [FIFO_PTR_W:0]   FULL_CNT = (FIFO_PTR_W + 1)'(CMD_FIFO_DEPTH);

  cmd_t                  mem_q [CMD_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_PTR_W:0]   count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("command queue count out of range");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |=> (count_q == FULL_CNT))
    else $error("command queue lost entries while full");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_o && push_i) |=> valid_o)
    else $error("command queue did not capture push into empty queue");

endmodule

@@ hw/rtl/arpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_back
// Register CAM of IP/MAC pairs; executes cache commands and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module arpc_back
  import arpc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  arpc_rsp_if.source rsp_o
);

  logic [CACHE_ENTRIES-1:0] entry_valid_q;
  logic [IP_W-1:0]          entry_ip_q  [CACHE_ENTRIES];
  logic [MAC_W-1:0]         entry_mac_q [CACHE_ENTRIES];

  logic [CACHE_ENTRIES-1:0] match;
  logic [IDX_W-1:0]         hit_idx, free_idx, wr_idx;
  logic                     hit, cam_we;

  logic             rsp_valid_q;
  logic             hit_q, written_q;
  logic [MAC_W-1:0] found_mac_q, dest_mac_q, tgt_mac_q;
  logic [IP_W-1:0]  tgt_ip_q;
  frame_kind_e      kind_q;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_valid_q[i] && (entry_ip_q[i] == cmd_i.ip);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign wr_idx    = hit ? hit_idx : free_idx;
  assign cmd_pop_o = cmd_valid_i && (!rsp_valid_q || rsp_o.ready);
  assign cam_we    = cmd_pop_o && (cmd_i.kind == CMD_LEARN || cmd_i.kind == CMD_ANSWER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
    end else if (cam_we) begin
      entry_valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cam_we) begin
      entry_mac_q[wr_idx] <= cmd_i.mac;
      if (!hit) begin
        entry_ip_q[wr_idx] <= cmd_i.ip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      hit_q       <= 1'b0;
      found_mac_q <= '0;
      written_q   <= 1'b0;
      kind_q      <= FRAME_NONE;
      dest_mac_q  <= '0;
      tgt_mac_q   <= '0;
      tgt_ip_q    <= '0;
      unique case (cmd_i.kind)
        CMD_LOOKUP: begin
          hit_q       <= hit;
          found_mac_q <= hit ? entry_mac_q[hit_idx] : '0;
        end
        CMD_LEARN: begin
          written_q <= 1'b1;
        end
        CMD_ANSWER: begin
          written_q  <= 1'b1;
          kind_q     <= FRAME_REPLY;
          dest_mac_q <= cmd_i.mac;
          tgt_mac_q  <= cmd_i.mac;
          tgt_ip_q   <= cmd_i.ip;
        end
        CMD_REQUEST: begin
          kind_q     <= FRAME_REQUEST;
          dest_mac_q <= MAC_BROADCAST;
          tgt_ip_q   <= cmd_i.ip;
        end
        default: begin
          hit_q <= 1'b0;
        end
      endcase
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.lookup_hit       = hit_q;
  assign rsp_o.found_mac        = found_mac_q;
  assign rsp_o.cache_written    = written_q;
  assign rsp_o.frame_kind       = kind_q;
  assign rsp_o.frame_dest_mac   = dest_mac_q;
  assign rsp_o.frame_target_mac = tgt_mac_q;
  assign rsp_o.frame_target_ip  = tgt_ip_q;

  // duplicates never enter: a known IP is only refreshed
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> $onehot0(match)) else $error("IP cached in more than one entry");

  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_we |=> entry_valid_q[$past(wr_idx)]) else $error("written entry not valid");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> (rsp_valid_q && $stable(tgt_ip_q) && $stable(kind_q)))
    else $error("stalled result changed");

endmodule
